@@ sv/wpsr_pkg.sv @@
// wpsr_pkg: beat types, register map and phase codes of the wheel pwm soft-start ramp
// used by wpsr_cfg, wpsr_div and wheel_pwm_soft_start_ramp_top; no dependencies
package wpsr_pkg;

  typedef struct packed {
    logic              wheel;
    logic signed [7:0] velocity;
    logic [31:0]       now_ms;
  } in_beat_t;

  typedef struct packed {
    logic signed [8:0] pwm_out;
    logic [2:0]        motion_phase;
  } out_beat_t;

  typedef struct packed {
    logic [6:0]  dead_zone;
    logic [15:0] ramp_ms;
    logic [15:0] hold_ms;
    logic [7:0]  fwd_max_pwm;
    logic [7:0]  fwd_mid_pwm;
    logic [7:0]  rev_max_pwm;
    logic [7:0]  rev_mid_pwm;
    logic [7:0]  boost_delta;
  } cfg_regs_t;

  localparam int CFG_AW = 5;

  localparam logic [2:0] REG_DEAD_ZONE   = 3'd0;
  localparam logic [2:0] REG_RAMP_MS     = 3'd1;
  localparam logic [2:0] REG_HOLD_MS     = 3'd2;
  localparam logic [2:0] REG_FWD_MAX_PWM = 3'd3;
  localparam logic [2:0] REG_FWD_MID_PWM = 3'd4;
  localparam logic [2:0] REG_REV_MAX_PWM = 3'd5;
  localparam logic [2:0] REG_REV_MID_PWM = 3'd6;
  localparam logic [2:0] REG_BOOST_DELTA = 3'd7;

  localparam logic [6:0]  RST_DEAD_ZONE   = 7'd4;
  localparam logic [15:0] RST_RAMP_MS     = 16'd750;
  localparam logic [15:0] RST_HOLD_MS     = 16'd300;
  localparam logic [7:0]  RST_MAX_PWM     = 8'd160;
  localparam logic [7:0]  RST_MID_PWM     = 8'd150;
  localparam logic [7:0]  RST_BOOST_DELTA = 8'd10;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ACCEL  = 3'd1;
  localparam logic [2:0] PH_HOLD   = 3'd2;
  localparam logic [2:0] PH_CRUISE = 3'd3;
  localparam logic [2:0] PH_BRAKE  = 3'd4;

  // divider: dividend up to 255 * 65535, divisor up to 65535
  localparam int DIV_NW = 24;
  localparam int DIV_DW = 16;
  localparam int DIV_CW = $clog2(DIV_NW);

  // division by 52 over 0..32640 as a multiply by ceil(2^21 / 52) and a shift
  localparam logic [15:0] SPEED_RECIP = 16'd40330;
  localparam int          SPEED_SHIFT = 21;

endpackage

@@ sv/wpsr_cfg.sv @@
// wpsr_cfg: apb register bank holding the ramp and pwm settings
// depends on wpsr_pkg
module wpsr_cfg
  import wpsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_regs_t         regs
);

  cfg_regs_t   regs_r;
  logic [2:0]  idx;
  logic        wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign regs   = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.dead_zone   <= RST_DEAD_ZONE;
      regs_r.ramp_ms     <= RST_RAMP_MS;
      regs_r.hold_ms     <= RST_HOLD_MS;
      regs_r.fwd_max_pwm <= RST_MAX_PWM;
      regs_r.fwd_mid_pwm <= RST_MID_PWM;
      regs_r.rev_max_pwm <= RST_MAX_PWM;
      regs_r.rev_mid_pwm <= RST_MID_PWM;
      regs_r.boost_delta <= RST_BOOST_DELTA;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEAD_ZONE:   regs_r.dead_zone   <= pwdata[6:0];
        REG_RAMP_MS:     regs_r.ramp_ms     <= pwdata[15:0];
        REG_HOLD_MS:     regs_r.hold_ms     <= pwdata[15:0];
        REG_FWD_MAX_PWM: regs_r.fwd_max_pwm <= pwdata[7:0];
        REG_FWD_MID_PWM: regs_r.fwd_mid_pwm <= pwdata[7:0];
        REG_REV_MAX_PWM: regs_r.rev_max_pwm <= pwdata[7:0];
        REG_REV_MID_PWM: regs_r.rev_mid_pwm <= pwdata[7:0];
        REG_BOOST_DELTA: regs_r.boost_delta <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEAD_ZONE:   prdata = {25'd0, regs_r.dead_zone};
      REG_RAMP_MS:     prdata = {16'd0, regs_r.ramp_ms};
      REG_HOLD_MS:     prdata = {16'd0, regs_r.hold_ms};
      REG_FWD_MAX_PWM: prdata = {24'd0, regs_r.fwd_max_pwm};
      REG_FWD_MID_PWM: prdata = {24'd0, regs_r.fwd_mid_pwm};
      REG_REV_MAX_PWM: prdata = {24'd0, regs_r.rev_max_pwm};
      REG_REV_MID_PWM: prdata = {24'd0, regs_r.rev_mid_pwm};
      REG_BOOST_DELTA: prdata = {24'd0, regs_r.boost_delta};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

@@ sv/wpsr_div.sv @@
// wpsr_div: shared restoring divider, one quotient bit per cycle
// depends on wpsr_pkg
module wpsr_div
  import wpsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              done,
  output logic [DIV_NW-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] dvs_r, dvs_nxt;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_r, quo_r[DIV_NW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_NW-2:0], fits};
      rem_nxt = fits ? DIV_DW'(trial - {1'b0, dvs_r}) : trial[DIV_DW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider did not start");
  a_done_idle  : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");

endmodule

@@ sv/wheel_pwm_soft_start_ramp_top.sv @@
// wheel_pwm_soft_start_ramp_top: per-wheel soft-start pwm profiler with sequencer and state
// depends on wpsr_pkg, wpsr_cfg, wpsr_div
//
//  channel  | ports                      | beat
//  ---------+----------------------------+--------------------------------
//  in       | in_valid/in_ready/in_data  | wheel, velocity, now_ms
//  out      | out_valid/out_ready/...    | pwm_out, motion_phase
//  cfg      | cfg_p* apb, 32 bit         | eight registers at 4*index
//
// an item for a valid wheel passes through load, target scaling by 52 (reciprocal multiply) for a
// speed outside the dead zone, evaluate, the shared divider for a ramp fraction while ramping, and
// writeback one item at a time; in_ready is high only when the sequencer is idle
// synchronous reset returns every wheel to idle, forward, level zero; no clearing pass
// a result waiting on out_ready holds only the writeback of the next item
module wheel_pwm_soft_start_ramp_top
  import wpsr_pkg::*;
#(
  parameter int NUM_WHEELS = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_beat_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_beat_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int WIDX_W = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_TDIV = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_RDIV = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;

  cfg_regs_t cfg;

  wpsr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (cfg)
  );

  // per-wheel state
  logic [7:0]  lvl_r   [NUM_WHEELS];
  logic [31:0] start_r [NUM_WHEELS];
  logic [2:0]  ph_r    [NUM_WHEELS];
  logic [7:0]  from_r  [NUM_WHEELS];
  logic [7:0]  tgt_r   [NUM_WHEELS];
  logic [7:0]  bst_r   [NUM_WHEELS];
  logic        rev_r   [NUM_WHEELS];

  logic [2:0]  state_r, state_nxt;
  logic        wheel_r;
  logic [7:0]  vel_r;
  logic [31:0] now_r;

  logic [7:0]  w_lvl_r, w_lvl_nxt;
  logic [31:0] w_start_r, w_start_nxt;
  logic [2:0]  w_ph_r, w_ph_nxt;
  logic [7:0]  w_from_r, w_from_nxt;
  logic [7:0]  w_tgt_r, w_tgt_nxt;
  logic [7:0]  w_bst_r, w_bst_nxt;
  logic        w_rev_r, w_rev_nxt;
  logic        tsign_r, tsign_nxt;
  logic [14:0] tprod_r, tprod_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_beat_t   out_data_r, out_data_nxt;

  logic [WIDX_W-1:0] idx;
  logic              wheel_ok;
  logic              neg;
  logic [7:0]        mag;
  logic [7:0]        mx, md;
  logic signed [8:0] diff;
  logic signed [8:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [25:0] prod;
  logic [25:0]       prod_mag;
  logic [30:0]       tscale;
  logic [31:0]       elapsed;
  logic              in_ramp;
  logic              div_start, div_done;
  logic [DIV_DW-1:0] div_divisor;
  logic [DIV_NW-1:0] div_q;
  logic signed [11:0] qs, tsum;
  logic [7:0]        tgt_c;
  logic [8:0]        bsum;
  logic [8:0]        lvl9;
  logic              wb_fire;

  assign idx      = WIDX_W'(wheel_r);
  assign wheel_ok = (32'(wheel_r) < 32'(NUM_WHEELS));
  assign neg      = vel_r[7];
  assign mag      = neg ? 8'(~vel_r + 8'd1) : vel_r;
  assign mx       = neg ? cfg.rev_max_pwm : cfg.fwd_max_pwm;
  assign md       = neg ? cfg.rev_mid_pwm : cfg.fwd_mid_pwm;
  assign diff     = $signed({1'b0, mx}) - $signed({1'b0, md});
  assign elapsed  = now_r - w_start_r;
  assign in_ramp  = elapsed < {16'd0, cfg.ramp_ms};

  // shared multiplier: speed scaling in load, ramp fraction in evaluate
  always_comb begin
    if (state_r == S_EVAL) begin
      mul_a = $signed({1'b0, (w_ph_r == PH_ACCEL) ? w_bst_r : w_from_r});
      mul_b = $signed({1'b0, elapsed[15:0]});
    end else begin
      mul_a = $signed({1'b0, mag});
      mul_b = 17'(diff);
    end
  end

  assign prod     = mul_a * mul_b;
  assign prod_mag = prod[25] ? 26'(-prod) : 26'(prod);
  assign tscale   = 31'(tprod_r) * 31'(SPEED_RECIP);

  assign div_divisor = cfg.ramp_ms;

  wpsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_mag[DIV_NW-1:0]),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // target and boost from the scaled speed
  always_comb begin
    qs   = $signed({2'b00, tscale[SPEED_SHIFT +: 10]});
    tsum = $signed({4'd0, md}) + (tsign_r ? -qs : qs);
    if (tsum[11]) begin
      tgt_c = 8'd0;
    end else if (tsum > 12'sd255) begin
      tgt_c = 8'd255;
    end else begin
      tgt_c = tsum[7:0];
    end
    bsum = {1'b0, tgt_c} + {1'b0, cfg.boost_delta};
  end

  assign wb_fire = (state_r == S_WB) && (!out_valid_r || out_ready);
  assign lvl9    = {1'b0, w_lvl_r};

  always_comb begin
    state_nxt   = state_r;
    w_lvl_nxt   = w_lvl_r;
    w_start_nxt = w_start_r;
    w_ph_nxt    = w_ph_r;
    w_from_nxt  = w_from_r;
    w_tgt_nxt   = w_tgt_r;
    w_bst_nxt   = w_bst_r;
    w_rev_nxt   = w_rev_r;
    tsign_nxt   = tsign_r;
    tprod_nxt   = tprod_r;
    div_start   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!wheel_ok) begin
          state_nxt = S_WB;
        end else begin
          w_lvl_nxt   = lvl_r[idx];
          w_start_nxt = start_r[idx];
          w_ph_nxt    = ph_r[idx];
          w_from_nxt  = from_r[idx];
          w_tgt_nxt   = tgt_r[idx];
          w_bst_nxt   = bst_r[idx];
          w_rev_nxt   = rev_r[idx];
          if (neg != rev_r[idx]) begin
            w_rev_nxt   = neg;
            w_ph_nxt    = PH_BRAKE;
            w_from_nxt  = lvl_r[idx];
            w_start_nxt = now_r;
          end
          if (mag > {1'b0, cfg.dead_zone}) begin
            if (w_ph_nxt == PH_IDLE) begin
              w_ph_nxt    = PH_ACCEL;
              w_start_nxt = now_r;
            end
            tsign_nxt = prod[25];
            tprod_nxt = prod_mag[14:0];
            state_nxt = S_TDIV;
          end else begin
            if (w_ph_nxt != PH_BRAKE && lvl_r[idx] != 8'd0) begin
              w_ph_nxt    = PH_BRAKE;
              w_from_nxt  = lvl_r[idx];
              w_start_nxt = now_r;
            end
            state_nxt = S_EVAL;
          end
        end
      end
      S_TDIV: begin
        w_tgt_nxt = tgt_c;
        w_bst_nxt = (bsum > {1'b0, mx}) ? mx : bsum[7:0];
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_WB;
        case (w_ph_r)
          PH_ACCEL: begin
            if (in_ramp) begin
              div_start = 1'b1;
              state_nxt = S_RDIV;
            end else begin
              w_lvl_nxt   = w_bst_r;
              w_ph_nxt    = PH_HOLD;
              w_start_nxt = now_r;
            end
          end
          PH_HOLD: begin
            if (elapsed >= {16'd0, cfg.hold_ms}) begin
              w_ph_nxt  = PH_CRUISE;
              w_lvl_nxt = w_tgt_r;
            end
          end
          PH_CRUISE: w_lvl_nxt = w_tgt_r;
          PH_BRAKE: begin
            if (in_ramp) begin
              div_start = 1'b1;
              state_nxt = S_RDIV;
            end else begin
              w_lvl_nxt = 8'd0;
              w_ph_nxt  = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      S_RDIV: begin
        if (div_done) begin
          w_lvl_nxt = (w_ph_r == PH_ACCEL) ? div_q[7:0] : w_from_r - div_q[7:0];
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (wb_fire) begin
          out_valid_nxt = 1'b1;
          if (wheel_ok) begin
            out_data_nxt.pwm_out      = w_rev_r ? 9'(-lvl9) : lvl9;
            out_data_nxt.motion_phase = w_ph_r;
          end else begin
            out_data_nxt.pwm_out      = 9'sd0;
            out_data_nxt.motion_phase = PH_IDLE;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      wheel_r <= in_data.wheel;
      vel_r   <= in_data.velocity;
      now_r   <= in_data.now_ms;
    end
    w_lvl_r    <= w_lvl_nxt;
    w_start_r  <= w_start_nxt;
    w_ph_r     <= w_ph_nxt;
    w_from_r   <= w_from_nxt;
    w_tgt_r    <= w_tgt_nxt;
    w_bst_r    <= w_bst_nxt;
    w_rev_r    <= w_rev_nxt;
    tsign_r    <= tsign_nxt;
    tprod_r    <= tprod_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        lvl_r[i]   <= 8'd0;
        start_r[i] <= 32'd0;
        ph_r[i]    <= PH_IDLE;
        from_r[i]  <= 8'd0;
        tgt_r[i]   <= 8'd0;
        bst_r[i]   <= 8'd0;
        rev_r[i]   <= 1'b0;
      end
    end else if (wb_fire && wheel_ok) begin
      lvl_r[idx]   <= w_lvl_r;
      start_r[idx] <= w_start_r;
      ph_r[idx]    <= w_ph_r;
      from_r[idx]  <= w_from_r;
      tgt_r[idx]   <= w_tgt_r;
      bst_r[idx]   <= w_bst_r;
      rev_r[idx]   <= w_rev_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_load : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_LOAD) else $error("accepted beat not loaded");
  a_done_wait   : assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_RDIV)
    else $error("quotient arrived with nobody waiting");
  a_idle_zero   : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.motion_phase == PH_IDLE |-> out_data.pwm_out == 9'sd0)
    else $error("idle wheel driven");

endmodule

@@ tb/sv/wheel_pwm_soft_start_ramp_top_test.sv @@
// wheel_pwm_soft_start_ramp_top_test: self-checking bench for the per-wheel soft-start pwm profiler
// a scoreboard class predicts each drive beat; tasks drive the apb and in channels
// depends on wpsr_pkg and wheel_pwm_soft_start_ramp_top
module wheel_pwm_soft_start_ramp_top_test
  import wpsr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WHEELS = 2;
  localparam int SPEED_STEPS = 52;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASES = 6;
  localparam int BEATS_PER_PHASE = 64;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_beat_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_beat_t         out_data;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  wheel_pwm_soft_start_ramp_top #(.NUM_WHEELS(WHEELS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  class pwm_profile_scoreboard;
    cfg_regs_t   cfg;
    logic [7:0]  level [WHEELS];
    logic [7:0]  brake_from [WHEELS];
    logic [7:0]  target [WHEELS];
    logic [7:0]  boost [WHEELS];
    logic [31:0] phase_start [WHEELS];
    logic [2:0]  phase [WHEELS];
    logic        reverse [WHEELS];
    out_beat_t   pending_drive [$];
    int          errors;

    function new();
      cfg.dead_zone = RST_DEAD_ZONE;
      cfg.ramp_ms = RST_RAMP_MS;
      cfg.hold_ms = RST_HOLD_MS;
      cfg.fwd_max_pwm = RST_MAX_PWM;
      cfg.fwd_mid_pwm = RST_MID_PWM;
      cfg.rev_max_pwm = RST_MAX_PWM;
      cfg.rev_mid_pwm = RST_MID_PWM;
      cfg.boost_delta = RST_BOOST_DELTA;
      for (int w = 0; w < WHEELS; w++) begin
        level[w] = '0;
        brake_from[w] = '0;
        target[w] = '0;
        boost[w] = '0;
        phase_start[w] = '0;
        phase[w] = PH_IDLE;
        reverse[w] = 1'b0;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_DEAD_ZONE:   cfg.dead_zone = value[6:0];
        REG_RAMP_MS:     cfg.ramp_ms = value[15:0];
        REG_HOLD_MS:     cfg.hold_ms = value[15:0];
        REG_FWD_MAX_PWM: cfg.fwd_max_pwm = value[7:0];
        REG_FWD_MID_PWM: cfg.fwd_mid_pwm = value[7:0];
        REG_REV_MAX_PWM: cfg.rev_max_pwm = value[7:0];
        REG_REV_MID_PWM: cfg.rev_mid_pwm = value[7:0];
        REG_BOOST_DELTA: cfg.boost_delta = value[7:0];
        default: ;
      endcase
    endfunction

    function void start_brake(int w, logic [31:0] now_ms);
      phase[w] = PH_BRAKE;
      brake_from[w] = level[w];
      phase_start[w] = now_ms;
    endfunction

    function void note_command(in_beat_t b);
      int          w;
      int          mag;
      int          mx;
      int          md;
      int          t;
      int          bst;
      logic        neg;
      logic [31:0] elapsed;
      logic [31:0] frac;
      logic [8:0]  lvl9;
      out_beat_t   e;
      w = b.wheel;
      neg = b.velocity[7];
      mag = (b.velocity < 0) ? -int'(b.velocity) : int'(b.velocity);
      if (neg != reverse[w]) begin
        reverse[w] = neg;
        start_brake(w, b.now_ms);
      end
      if (mag > int'(cfg.dead_zone)) begin
        mx = neg ? int'(cfg.rev_max_pwm) : int'(cfg.fwd_max_pwm);
        md = neg ? int'(cfg.rev_mid_pwm) : int'(cfg.fwd_mid_pwm);
        t = md + (mag * (mx - md)) / SPEED_STEPS;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        bst = t + int'(cfg.boost_delta);
        if (bst > mx) bst = mx;
        if (bst < 0) bst = 0;
        target[w] = t[7:0];
        boost[w] = bst[7:0];
        if (phase[w] == PH_IDLE) begin
          phase[w] = PH_ACCEL;
          phase_start[w] = b.now_ms;
        end
      end else if (phase[w] != PH_BRAKE && level[w] != 8'd0) begin
        start_brake(w, b.now_ms);
      end
      elapsed = b.now_ms - phase_start[w];
      case (phase[w])
        PH_ACCEL: begin
          if (elapsed < 32'(cfg.ramp_ms)) begin
            frac = (32'(boost[w]) * elapsed) / 32'(cfg.ramp_ms);
            level[w] = frac[7:0];
          end else begin
            level[w] = boost[w];
            phase[w] = PH_HOLD;
            phase_start[w] = b.now_ms;
          end
        end
        PH_HOLD: begin
          if (elapsed >= 32'(cfg.hold_ms)) begin
            phase[w] = PH_CRUISE;
            level[w] = target[w];
          end
        end
        PH_CRUISE: level[w] = target[w];
        PH_BRAKE: begin
          if (elapsed < 32'(cfg.ramp_ms)) begin
            frac = (32'(brake_from[w]) * elapsed) / 32'(cfg.ramp_ms);
            level[w] = brake_from[w] - frac[7:0];
          end else begin
            level[w] = 8'd0;
            phase[w] = PH_IDLE;
          end
        end
        default: ;
      endcase
      lvl9 = {1'b0, level[w]};
      e.pwm_out = reverse[w] ? (9'd0 - lvl9) : lvl9;
      e.motion_phase = phase[w];
      pending_drive.push_back(e);
    endfunction

    function void check_drive(out_beat_t got);
      out_beat_t e;
      if (pending_drive.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: pwm %0d phase %0d", got.pwm_out, got.motion_phase);
        return;
      end
      e = pending_drive.pop_front();
      if (got.pwm_out !== e.pwm_out || got.motion_phase !== e.motion_phase) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected pwm %0d phase %0d, got pwm %0d phase %0d",
                   e.pwm_out, e.motion_phase, got.pwm_out, got.motion_phase);
      end
    endfunction

    function int pending();
      return pending_drive.size();
    endfunction
  endclass

  pwm_profile_scoreboard sb = new();
  int          gap_pct = 0;
  int          stall_pct = 0;
  logic [31:0] clock_ms = '0;
  logic        cmd_neg [WHEELS] = '{1'b0, 1'b0};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_drive(out_data);
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_psel && cfg_penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic apply_settings(cfg_regs_t c);
    write_reg(REG_DEAD_ZONE, 32'(c.dead_zone));
    write_reg(REG_RAMP_MS, 32'(c.ramp_ms));
    write_reg(REG_HOLD_MS, 32'(c.hold_ms));
    write_reg(REG_FWD_MAX_PWM, 32'(c.fwd_max_pwm));
    write_reg(REG_FWD_MID_PWM, 32'(c.fwd_mid_pwm));
    write_reg(REG_REV_MAX_PWM, 32'(c.rev_max_pwm));
    write_reg(REG_REV_MID_PWM, 32'(c.rev_mid_pwm));
    write_reg(REG_BOOST_DELTA, 32'(c.boost_delta));
  endtask

  function automatic cfg_regs_t settings(int dz, int ramp, int hold, int fmax, int fmid,
                                         int rmax, int rmid, int delta);
    cfg_regs_t c;
    c.dead_zone = dz[6:0];
    c.ramp_ms = ramp[15:0];
    c.hold_ms = hold[15:0];
    c.fwd_max_pwm = fmax[7:0];
    c.fwd_mid_pwm = fmid[7:0];
    c.rev_max_pwm = rmax[7:0];
    c.rev_mid_pwm = rmid[7:0];
    c.boost_delta = delta[7:0];
    return c;
  endfunction

  task automatic push_item(in_beat_t b);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_command(b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic directed_beat(bit w, int v, int dt);
    in_beat_t b;
    clock_ms = clock_ms + 32'(dt);
    b.wheel = w;
    b.velocity = 8'(v);
    b.now_ms = clock_ms;
    push_item(b);
  endtask

  function automatic in_beat_t random_command();
    in_beat_t b;
    int       r;
    int       w;
    int       dz;
    int       mag;
    int       step_max;
    logic     neg;
    w = $urandom_range(WHEELS - 1);
    dz = sb.cfg.dead_zone;
    r = $urandom_range(99);
    b.wheel = w[0];
    if (r < 10) begin
      b.velocity = 8'($urandom_range(255));
    end else begin
      neg = (r < 22) ? !cmd_neg[w] : cmd_neg[w];
      cmd_neg[w] = neg;
      if (r >= 85 || (!neg && dz >= 127))
        mag = $urandom_range(dz);
      else
        mag = $urandom_range(neg ? 128 : 127, dz + 1);
      b.velocity = neg ? 8'(-mag) : 8'(mag);
    end
    step_max = (int'(sb.cfg.ramp_ms) + int'(sb.cfg.hold_ms)) / 3 + 4;
    r = $urandom_range(99);
    if (r < 85)
      clock_ms = clock_ms + $urandom_range(step_max);
    else if (r < 95)
      clock_ms = clock_ms + $urandom_range(3);
    else
      clock_ms = $urandom();
    b.now_ms = clock_ms;
    return b;
  endfunction

  initial begin
    cfg_regs_t plan [PHASES];
    plan[0] = settings(4, 750, 300, 160, 150, 160, 150, 10);
    plan[1] = settings(0, 1, 0, 255, 0, 0, 255, 255);
    plan[2] = settings(127, 65535, 65535, 255, 255, 255, 0, 0);
    plan[3] = settings($urandom_range(10), 0, $urandom_range(200), $urandom_range(255),
                       $urandom_range(255), $urandom_range(255), $urandom_range(255),
                       $urandom_range(255));
    for (int p = 4; p < PHASES; p++)
      plan[p] = settings($urandom_range(16), $urandom_range(3000, 1), $urandom_range(2000),
                         $urandom_range(255), $urandom_range(255), $urandom_range(255),
                         $urandom_range(255), $urandom_range(255));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apply_settings(plan[p]);
      end
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 45; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 33; stall_pct = 33; end
      endcase
      clock_ms = p[0] ? (32'hFFFF_FFFF - $urandom_range(20000)) : $urandom();
      if (p == 0) begin
        // wrap of now_ms falls inside the first ramp
        clock_ms = 32'hFFFF_FE00;
        directed_beat(0, 0, 0);
        directed_beat(0, 127, 0);
        directed_beat(0, 127, 375);
        directed_beat(0, 127, 374);
        directed_beat(0, 127, 1);
        directed_beat(0, 100, 299);
        directed_beat(0, 100, 1);
        directed_beat(0, 5, 10);
        directed_beat(0, 4, 10);
        directed_beat(0, 4, 375);
        directed_beat(0, 0, 375);
        directed_beat(1, -128, 5);
        directed_beat(1, -128, 750);
        directed_beat(1, -128, 1);
        directed_beat(1, -5, 800);
        directed_beat(1, 1, 1);
        directed_beat(1, -4, 1);
        directed_beat(1, -1, 800);
        directed_beat(0, -127, 3);
        directed_beat(0, 127, 3);
        directed_beat(0, -128, 0);
      end
      for (int i = 0; i < BEATS_PER_PHASE; i++) begin
        if (i == BEATS_PER_PHASE / 2) wait_drained();
        push_item(random_command());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
